FILE: design/tca_pkg.sv
// ----------------------------------------------------------------------------
// tca_pkg
// Shared types and constants of the torus cellular automaton engine.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int ROWS_DEF    = 64;
  localparam int COLUMNS_DEF = 64;
  localparam int COLOURS_DEF = 8;

  localparam int COLOUR_W = 3;
  localparam int COORD_W  = 6;
  localparam int RULE_AW  = 15;
  localparam int CHANGE_W = 13;

  localparam logic [RULE_AW-1:0]  RULE_LAST  = '1;
  localparam logic [CHANGE_W-1:0] CHANGE_MAX = '1;

  typedef logic [COLOUR_W-1:0] colour_t;

  typedef enum logic [1:0] {
    OP_RULE_WR  = 2'd0,
    OP_CELL_WR  = 2'd1,
    OP_CELL_RD  = 2'd2,
    OP_GENERATE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_GLOAD0,
    ST_GLOAD1,
    ST_GLOAD2,
    ST_GRUN,
    ST_GNEXT,
    ST_GFLUSH,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    op_t                 operation;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
    colour_t             cell_colour;
    logic [RULE_AW-1:0]  rule_index;
    colour_t             rule_colour;
  } item_t;

  typedef struct packed {
    logic               we;
    logic [RULE_AW-1:0] waddr;
    colour_t            wdata;
    logic [RULE_AW-1:0] raddr;
  } rule_port_t;

  typedef struct packed {
    colour_t             read_colour;
    logic [CHANGE_W-1:0] changed_cells;
    logic                uniform;
  } result_t;

endpackage

FILE: design/tca_rule_mem.sv
// ----------------------------------------------------------------------------
// tca_rule_mem
// Rule table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tca_rule_mem
  import tca_pkg::*;
(
  input  logic       clk,
  input  rule_port_t port,
  output colour_t    rdata
);

  colour_t mem [2**RULE_AW];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rdata <= mem[port.raddr];
  end

endmodule

FILE: design/tca_grid_mem.sv
// ----------------------------------------------------------------------------
// tca_grid_mem
// Grid store, one grid row per word, two banks selected by the address MSB.
// ----------------------------------------------------------------------------
module tca_grid_mem
  import tca_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF,
  localparam int GAW    = $clog2(ROWS) + 1
)(
  input  logic                             clk,
  input  logic                             we,
  input  logic [GAW-1:0]                   waddr,
  input  logic [COLUMNS-1:0][COLOUR_W-1:0] wdata,
  input  logic [GAW-1:0]                   raddr,
  output logic [COLUMNS-1:0][COLOUR_W-1:0] rdata
);

  logic [COLUMNS-1:0][COLOUR_W-1:0] mem [2**GAW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tca_seq.sv
// ----------------------------------------------------------------------------
// tca_seq
// Sequencer and cell datapath: clearing pass, cell access, generation sweep
// over rotating row windows with a one-stage rule lookup pipeline.
// ----------------------------------------------------------------------------
module tca_seq
  import tca_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int COLOURS = COLOURS_DEF,
  localparam int RW     = $clog2(ROWS),
  localparam int CW     = $clog2(COLUMNS),
  localparam int GAW    = RW + 1
)(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  item_t                            item,
  output logic                             res_valid,
  input  logic                             res_ready,
  output result_t                          res,
  output rule_port_t                       rp,
  input  colour_t                          rule_rdata,
  output logic                             g_we,
  output logic [GAW-1:0]                   g_waddr,
  output logic [COLUMNS-1:0][COLOUR_W-1:0] g_wdata,
  output logic [GAW-1:0]                   g_raddr,
  input  logic [COLUMNS-1:0][COLOUR_W-1:0] g_rdata
);

  localparam int         GRID_DEPTH = 2**GAW;
  localparam colour_t    COLOUR_MAX = COLOUR_W'(COLOURS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  typedef logic [COLUMNS-1:0][COLOUR_W-1:0] row_t;

  seq_state_t state, state_next;

  op_t           op_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          inside_q;
  colour_t       colour_q;

  logic               bank;
  logic [RULE_AW-1:0] clr_addr;

  logic [RW-1:0] grow;
  logic [CW-1:0] gcol;
  logic [RW-1:0] grow_s;
  logic [RW-1:0] grow_s2;

  row_t north, centre, south, nrow, row_mod;

  logic          p_v, p_last, p_first;
  colour_t       p_old;
  logic [RW-1:0] p_row;
  logic          w_pend;
  logic [RW-1:0] w_row;

  colour_t             first;
  logic [CHANGE_W-1:0] cnt;
  logic                same;

  assign grow_s  = (grow == ROW_LAST) ? '0 : grow + 1'b1;
  assign grow_s2 = (grow_s == ROW_LAST) ? '0 : grow_s + 1'b1;

  always_comb begin
    row_mod        = g_rdata;
    row_mod[col_q] = colour_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    g_raddr    = '0;
    g_we       = 1'b0;
    g_waddr    = {~bank, w_row};
    g_wdata    = nrow;
    rp.we      = 1'b0;
    rp.waddr   = item.rule_index;
    rp.wdata   = (item.rule_colour > COLOUR_MAX) ? COLOUR_MAX : item.rule_colour;
    rp.raddr   = {north[0], south[0], centre[COLUMNS-1], centre[1], centre[0]};
    if (w_pend) begin
      g_we = 1'b1;
    end
    unique case (state)
      ST_CLEAR: begin
        rp.we    = 1'b1;
        rp.waddr = clr_addr;
        rp.wdata = '0;
        if (int'(clr_addr) < GRID_DEPTH) begin
          g_we    = 1'b1;
          g_waddr = GAW'(clr_addr);
          g_wdata = '0;
        end
        if (clr_addr == RULE_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (item.operation)
            OP_RULE_WR: begin
              rp.we      = 1'b1;
              state_next = ST_DONE;
            end
            OP_CELL_WR, OP_CELL_RD: begin
              g_raddr    = {bank, RW'(item.row)};
              state_next = ST_CELL;
            end
            OP_GENERATE: begin
              g_raddr    = {bank, ROW_LAST};
              state_next = ST_GLOAD0;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CELL: begin
        if (op_q == OP_CELL_WR && inside_q) begin
          g_we    = 1'b1;
          g_waddr = {bank, row_q};
          g_wdata = row_mod;
        end
        state_next = ST_DONE;
      end
      ST_GLOAD0: begin
        g_raddr    = {bank, RW'(0)};
        state_next = ST_GLOAD1;
      end
      ST_GLOAD1: begin
        g_raddr    = {bank, RW'(1)};
        state_next = ST_GLOAD2;
      end
      ST_GLOAD2: begin
        state_next = ST_GRUN;
      end
      ST_GRUN: begin
        if (gcol == COL_LAST) begin
          g_raddr    = {bank, grow_s2};
          state_next = ST_GNEXT;
        end
      end
      ST_GNEXT: begin
        state_next = (grow == ROW_LAST) ? ST_GFLUSH : ST_GRUN;
      end
      ST_GFLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      bank     <= 1'b0;
      p_v      <= 1'b0;
      w_pend   <= 1'b0;
    end else begin
      p_v    <= (state == ST_GRUN);
      w_pend <= p_v && p_last;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_GFLUSH) begin
        bank <= ~bank;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_q     <= item.operation;
      row_q    <= RW'(item.row);
      col_q    <= CW'(item.column);
      inside_q <= (int'(item.row) < ROWS) && (int'(item.column) < COLUMNS);
      colour_q <= (item.cell_colour > COLOUR_MAX) ? COLOUR_MAX : item.cell_colour;
      cnt      <= '0;
      same     <= 1'b1;
      res      <= '0;
    end
    if (state == ST_CELL) begin
      res.read_colour <= (op_q == OP_CELL_RD && inside_q) ? g_rdata[col_q] : '0;
    end
    if (state == ST_GLOAD0) begin
      north <= g_rdata;
    end
    if (state == ST_GLOAD1) begin
      centre <= g_rdata;
    end
    if (state == ST_GLOAD2) begin
      south <= g_rdata;
      grow  <= '0;
      gcol  <= '0;
    end
    if (state == ST_GRUN) begin
      centre  <= {centre[0], centre[COLUMNS-1:1]};
      north   <= {north[0], north[COLUMNS-1:1]};
      south   <= {south[0], south[COLUMNS-1:1]};
      gcol    <= gcol + 1'b1;
      p_old   <= centre[0];
      p_last  <= (gcol == COL_LAST);
      p_first <= (grow == '0) && (gcol == '0);
      p_row   <= grow;
    end
    if (state == ST_GNEXT) begin
      north <= centre;
      centre <= south;
      south <= g_rdata;
      grow  <= grow_s;
      gcol  <= '0;
    end
    if (p_v) begin
      nrow <= {rule_rdata, nrow[COLUMNS-1:1]};
      if (rule_rdata != p_old && cnt != CHANGE_MAX) begin
        cnt <= cnt + 1'b1;
      end
      if (p_first) begin
        first <= rule_rdata;
      end else if (rule_rdata != first) begin
        same <= 1'b0;
      end
      if (p_last) begin
        w_row <= p_row;
      end
    end
    if (state == ST_GFLUSH) begin
      res.changed_cells <= cnt;
      res.uniform       <= same;
    end
  end

  a_gen_writes_other_bank: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GRUN || state == ST_GNEXT) && g_we |-> g_waddr[GAW-1] != bank)
    else $error("generation write hit the bank being read");

  a_next_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_GNEXT |-> p_v && p_last)
    else $error("lookup pipeline out of step with row end");

  a_flush_writes_last_row: assert property (@(posedge clk) disable iff (rst)
    state == ST_GFLUSH |-> w_pend && w_row == ROW_LAST)
    else $error("final row write missing at flush");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    p_v && cnt == CHANGE_MAX |=> cnt == CHANGE_MAX)
    else $error("change count wrapped");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    bank != $past(bank) |-> $past(state) == ST_GFLUSH)
    else $error("bank flipped outside a generation end");

endmodule

FILE: design/torus_ca_generation_engine.sv
// ----------------------------------------------------------------------------
// torus_ca_generation_engine
// Eight-color cellular automaton on a wrapping ROWS x COLUMNS grid with a
// 32768-entry rule table indexed by centre, east, west, south and north.
// After reset the block clears the rule table and grid and accepts no item
// until done. Items run one at a time; a generation's length is set by the
// single rule table read port, which looks up one cell per cycle plus one row
// reload per grid row. One result waits in the output register while the next
// item is accepted.
// ----------------------------------------------------------------------------
module torus_ca_generation_engine
  import tca_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int COLOURS = COLOURS_DEF
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [COORD_W-1:0]  row,
  input  logic [COORD_W-1:0]  column,
  input  logic [COLOUR_W-1:0] cell_colour,
  input  logic [RULE_AW-1:0]  rule_index,
  input  logic [COLOUR_W-1:0] rule_colour,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOUR_W-1:0] read_colour,
  output logic [CHANGE_W-1:0] changed_cells,
  output logic                uniform
);

  localparam int GAW = $clog2(ROWS) + 1;

  item_t      item;
  result_t    res, out_q;
  logic       res_valid, res_ready;
  rule_port_t rp;
  colour_t    rule_rdata;

  logic                             g_we;
  logic [GAW-1:0]                   g_waddr, g_raddr;
  logic [COLUMNS-1:0][COLOUR_W-1:0] g_wdata, g_rdata;

  assign item = '{operation:   op_t'(operation),
                  row:         row,
                  column:      column,
                  cell_colour: cell_colour,
                  rule_index:  rule_index,
                  rule_colour: rule_colour};

  tca_seq #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .COLOURS (COLOURS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .rp         (rp),
    .rule_rdata (rule_rdata),
    .g_we       (g_we),
    .g_waddr    (g_waddr),
    .g_wdata    (g_wdata),
    .g_raddr    (g_raddr),
    .g_rdata    (g_rdata)
  );

  tca_rule_mem u_rule_mem (
    .clk   (clk),
    .port  (rp),
    .rdata (rule_rdata)
  );

  tca_grid_mem #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_grid_mem (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  assign res_ready = !out_valid || out_ready;

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign read_colour   = out_q.read_colour;
  assign changed_cells = out_q.changed_cells;
  assign uniform       = out_q.uniform;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for torus_ca_generation_engine. A directed table covers
// the reset state, the grid corners, the colour extremes and the all-cell
// flood, then random sequences of cell writes, neighbourhood rule writes,
// generations and reads run against a behavioral copy of grid and rule table.
// Both handshakes are paced at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tca_pkg::*;

  localparam int CELLS        = ROWS_DEF * COLUMNS_DEF;
  localparam int RULE_DEPTH   = 1 << RULE_AW;
  localparam int DIRECTED_N   = 23;
  localparam int RANDOM_ITEMS = 117;
  localparam int LONG_HOLD    = 400;
  localparam int LIMIT_CYCLES = 3_000_000;

  typedef struct {
    op_t                op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    colour_t            cell_colour;
    logic [RULE_AW-1:0] rule_index;
    colour_t            rule_colour;
    bit                 typed;
    result_t            want;
  } stim_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          operation = '0;
  logic [COORD_W-1:0]  row = '0;
  logic [COORD_W-1:0]  column = '0;
  logic [COLOUR_W-1:0] cell_colour = '0;
  logic [RULE_AW-1:0]  rule_index = '0;
  logic [COLOUR_W-1:0] rule_colour = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COLOUR_W-1:0] read_colour;
  logic [CHANGE_W-1:0] changed_cells;
  logic                uniform;

  colour_t grid_model [CELLS];
  colour_t rule_model [RULE_DEPTH];
  result_t pending_results [$];

  int beats_sent = 0;
  int burst_left = 0;
  int mismatches = 0;
  int hold_req   = 0;

  torus_ca_generation_engine dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .row           (row),
    .column        (column),
    .cell_colour   (cell_colour),
    .rule_index    (rule_index),
    .rule_colour   (rule_colour),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_colour   (read_colour),
    .changed_cells (changed_cells),
    .uniform       (uniform)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic colour_t fit_colour(colour_t c);
    return (c >= COLOURS_DEF) ? colour_t'(COLOURS_DEF - 1) : c;
  endfunction

  function automatic logic [RULE_AW-1:0] hood_index(int r, int c);
    int rs, rn, ce, cw;
    rs = (r + 1) % ROWS_DEF;
    rn = (r + ROWS_DEF - 1) % ROWS_DEF;
    ce = (c + 1) % COLUMNS_DEF;
    cw = (c + COLUMNS_DEF - 1) % COLUMNS_DEF;
    return {grid_model[rn * COLUMNS_DEF + c], grid_model[rs * COLUMNS_DEF + c],
            grid_model[r * COLUMNS_DEF + cw], grid_model[r * COLUMNS_DEF + ce],
            grid_model[r * COLUMNS_DEF + c]};
  endfunction

  function automatic result_t predict_item(stim_t s);
    result_t r;
    colour_t nxt [CELLS];
    int      count;
    bit      same;
    bit      in_grid;
    r = '0;
    in_grid = (s.row < ROWS_DEF) && (s.column < COLUMNS_DEF);
    case (s.op)
      OP_RULE_WR: begin
        rule_model[s.rule_index] = fit_colour(s.rule_colour);
      end
      OP_CELL_WR: begin
        if (in_grid) grid_model[s.row * COLUMNS_DEF + s.column] = fit_colour(s.cell_colour);
      end
      OP_CELL_RD: begin
        if (in_grid) r.read_colour = grid_model[s.row * COLUMNS_DEF + s.column];
      end
      default: begin
        for (int i = 0; i < ROWS_DEF; i++)
          for (int j = 0; j < COLUMNS_DEF; j++)
            nxt[i * COLUMNS_DEF + j] = rule_model[hood_index(i, j)];
        count = 0;
        same = 1'b1;
        for (int k = 0; k < CELLS; k++) begin
          if (nxt[k] != grid_model[k]) count++;
          if (nxt[k] != nxt[0]) same = 1'b0;
          grid_model[k] = nxt[k];
        end
        r.changed_cells = (count > CHANGE_MAX) ? CHANGE_MAX : CHANGE_W'(count);
        r.uniform = same;
      end
    endcase
    return r;
  endfunction

  function automatic stim_t mk(op_t op, int r, int c, int cc, int ri, int rc,
                               bit typed, int rd, int chg, int uni);
    stim_t s;
    s.op = op;
    s.row = COORD_W'(r);
    s.column = COORD_W'(c);
    s.cell_colour = COLOUR_W'(cc);
    s.rule_index = RULE_AW'(ri);
    s.rule_colour = COLOUR_W'(rc);
    s.typed = typed;
    s.want.read_colour = COLOUR_W'(rd);
    s.want.changed_cells = CHANGE_W'(chg);
    s.want.uniform = uni[0];
    return s;
  endfunction

  function automatic stim_t rand_beat();
    return mk(op_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom_range(0, 7), $urandom_range(0, RULE_DEPTH - 1),
              $urandom_range(0, 7), 1'b0, 0, 0, 0);
  endfunction

  function automatic int near(int base, int span);
    return (base + span - 1 + $urandom_range(0, 2)) % span;
  endfunction

  task automatic send_beat(stim_t s);
    int gap;
    result_t got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    operation   <= s.op;
    row         <= s.row;
    column      <= s.column;
    cell_colour <= s.cell_colour;
    rule_index  <= s.rule_index;
    rule_colour <= s.rule_colour;
    do @(posedge clk); while (!(in_valid && in_ready));
    got = predict_item(s);
    pending_results.push_back(s.typed ? s.want : got);
    beats_sent++;
  endtask

  initial begin : stimulus
    stim_t directed [DIRECTED_N];
    stim_t s;
    int    base_r, base_c, n;
    bit    held;
    foreach (grid_model[i]) grid_model[i] = '0;
    foreach (rule_model[i]) rule_model[i] = '0;

    directed[0]  = mk(OP_CELL_RD,   0,  0, 0, 0,     0, 1, 0, 0,    0);
    directed[1]  = mk(OP_CELL_RD,  63, 63, 0, 0,     0, 1, 0, 0,    0);
    directed[2]  = mk(OP_GENERATE,  0,  0, 0, 0,     0, 1, 0, 0,    1);
    directed[3]  = mk(OP_RULE_WR,   0,  0, 0, 32767, 7, 1, 0, 0,    0);
    directed[4]  = mk(OP_RULE_WR,   0,  0, 0, 0,     0, 1, 0, 0,    0);
    directed[5]  = mk(OP_CELL_WR,  63, 63, 7, 0,     0, 1, 0, 0,    0);
    directed[6]  = mk(OP_CELL_WR,   0,  0, 0, 0,     0, 1, 0, 0,    0);
    directed[7]  = mk(OP_CELL_RD,  63, 63, 0, 0,     0, 1, 7, 0,    0);
    directed[8]  = mk(OP_GENERATE,  0,  0, 0, 0,     0, 1, 0, 1,    1);
    directed[9]  = mk(OP_CELL_RD,  63, 63, 0, 0,     0, 1, 0, 0,    0);
    directed[10] = mk(OP_RULE_WR,   0,  0, 0, 0,     5, 1, 0, 0,    0);
    directed[11] = mk(OP_GENERATE,  0,  0, 0, 0,     0, 1, 0, 4096, 1);
    directed[12] = mk(OP_RULE_WR,   0,  0, 0, 23405, 5, 1, 0, 0,    0);
    directed[13] = mk(OP_GENERATE,  0,  0, 0, 0,     0, 1, 0, 0,    1);
    directed[14] = mk(OP_CELL_WR,   0,  0, 2, 0,     0, 1, 0, 0,    0);
    directed[15] = mk(OP_CELL_RD,   0,  0, 0, 0,     0, 1, 2, 0,    0);
    directed[16] = mk(OP_GENERATE,  0,  0, 0, 0,     0, 0, 0, 0,    0);
    directed[17] = mk(OP_CELL_RD,   0,  1, 0, 0,     0, 0, 0, 0,    0);
    directed[18] = mk(OP_CELL_RD,  63,  0, 0, 0,     0, 0, 0, 0,    0);
    directed[19] = mk(OP_RULE_WR,   0,  0, 0, 16384, 6, 0, 0, 0,    0);
    directed[20] = mk(OP_CELL_WR,   0, 63, 3, 0,     0, 0, 0, 0,    0);
    directed[21] = mk(OP_GENERATE,  0,  0, 0, 0,     0, 0, 0, 0,    0);
    directed[22] = mk(OP_CELL_RD,   0, 63, 0, 0,     0, 0, 0, 0,    0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_beat(directed[i]);

    held = 1'b0;
    while (beats_sent < DIRECTED_N + RANDOM_ITEMS) begin
      if (!held && beats_sent >= DIRECTED_N + 60) begin
        // hold the output and keep offering beats, then drain
        held = 1'b1;
        hold_req <= hold_req + 1;
        burst_left = 16;
        repeat (12) begin
          s = rand_beat();
          s.op = OP_CELL_RD;
          send_beat(s);
        end
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end else if ($urandom_range(0, 99) < 15) begin
        send_beat(rand_beat());
      end else begin
        base_r = $urandom_range(0, ROWS_DEF - 1);
        base_c = $urandom_range(0, COLUMNS_DEF - 1);
        n = $urandom_range(1, 6);
        repeat (n) begin
          s = rand_beat();
          s.op = OP_CELL_WR;
          if ($urandom_range(0, 1) == 1) begin
            s.row = COORD_W'(near(base_r, ROWS_DEF));
            s.column = COORD_W'(near(base_c, COLUMNS_DEF));
          end
          send_beat(s);
        end
        n = $urandom_range(1, 5);
        repeat (n) begin
          s = rand_beat();
          s.op = OP_RULE_WR;
          case ($urandom_range(0, 7))
            0:       s.rule_index = '0;
            1, 2:    ;
            default: s.rule_index = hood_index(near(base_r, ROWS_DEF), near(base_c, COLUMNS_DEF));
          endcase
          send_beat(s);
        end
        s = rand_beat();
        s.op = OP_GENERATE;
        send_beat(s);
        n = $urandom_range(1, 3);
        repeat (n) begin
          s = rand_beat();
          s.op = OP_CELL_RD;
          s.row = COORD_W'(near(base_r, ROWS_DEF));
          s.column = COORD_W'(near(base_c, COLUMNS_DEF));
          send_beat(s);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : receiver
    int hold_seen;
    int mode;
    int mode_left;
    hold_seen = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 400);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: read_colour %0d changed_cells %0d uniform %0d",
               read_colour, changed_cells, uniform);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (read_colour !== want.read_colour) begin
          $error("read_colour: expected %0d, actual %0d", want.read_colour, read_colour);
          mismatches++;
        end
        if (changed_cells !== want.changed_cells) begin
          $error("changed_cells: expected %0d, actual %0d", want.changed_cells, changed_cells);
          mismatches++;
        end
        if (uniform !== want.uniform) begin
          $error("uniform: expected %0d, actual %0d", want.uniform, uniform);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("testbench: errors");
    $finish;
  end

endmodule
